// ----- rtl/qrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 41;

    typedef enum logic [1:0] {
        KIND_TWO     = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_NOLEAD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg1;
        logic  neg2;
    } t_div_side;

endpackage
`default_nettype wire

// ----- rtl/qrs_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 34
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2*ROOT_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output logic [ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int REM_W = ROOT_W + 3;
    localparam int RAD_W = 2 * ROOT_W;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic [ROOT_W-1:0] r_v;

    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [RAD_W-1:0]  n_rad  [ROOT_W];
    logic [SIDE_W-1:0] n_side [ROOT_W];
    logic [ROOT_W-1:0] n_v;

    // one result bit per stage, restoring
    always_comb begin
        logic [REM_W-1:0]  s_rem;
        logic [REM_W-1:0]  t_rem;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] s_root;
        logic [RAD_W-1:0]  s_rad;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                s_rem     = '0;
                s_root    = '0;
                s_rad     = i_rad;
                n_side[k] = i_side;
                n_v[k]    = i_valid;
            end else begin
                s_rem     = r_rem[k-1];
                s_root    = r_root[k-1];
                s_rad     = r_rad[k-1];
                n_side[k] = r_side[k-1];
                n_v[k]    = r_v[k-1];
            end
            t_rem    = {s_rem[REM_W-3:0], s_rad[RAD_W-1 -: 2]};
            trial    = REM_W'({s_root, 2'b01});
            n_rad[k] = {s_rad[RAD_W-3:0], 2'b00};
            if (t_rem >= trial) begin
                n_rem[k]  = t_rem - trial;
                n_root[k] = {s_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = t_rem;
                n_root[k] = {s_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule
`default_nettype wire

// ----- rtl/qrs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num1,
    input  wire logic [NUM_W-1:0]  i_num2,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire t_div_side         i_side,
    output logic                   o_valid,
    output logic [NUM_W-1:0]       o_quo1,
    output logic [NUM_W-1:0]       o_quo2,
    output t_div_side              o_side
);

    logic [DEN_W-1:0] r_rem1 [NUM_W];
    logic [DEN_W-1:0] r_rem2 [NUM_W];
    logic [NUM_W-1:0] r_num1 [NUM_W];
    logic [NUM_W-1:0] r_num2 [NUM_W];
    logic [DEN_W-1:0] r_den  [NUM_W];
    t_div_side        r_side [NUM_W];
    logic [NUM_W-1:0] r_v;

    logic [DEN_W-1:0] n_rem1 [NUM_W];
    logic [DEN_W-1:0] n_rem2 [NUM_W];
    logic [NUM_W-1:0] n_num1 [NUM_W];
    logic [NUM_W-1:0] n_num2 [NUM_W];
    logic [DEN_W-1:0] n_den  [NUM_W];
    t_div_side        n_side [NUM_W];
    logic [NUM_W-1:0] n_v;

    // two lanes share a divisor; quotient bits shift in from the bottom
    always_comb begin
        logic [DEN_W-1:0] s_rem1;
        logic [DEN_W-1:0] s_rem2;
        logic [NUM_W-1:0] s_num1;
        logic [NUM_W-1:0] s_num2;
        logic [DEN_W:0]   t1;
        logic [DEN_W:0]   t2;
        logic [DEN_W:0]   d;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                s_rem1    = '0;
                s_rem2    = '0;
                s_num1    = i_num1;
                s_num2    = i_num2;
                n_den[k]  = i_den;
                n_side[k] = i_side;
                n_v[k]    = i_valid;
            end else begin
                s_rem1    = r_rem1[k-1];
                s_rem2    = r_rem2[k-1];
                s_num1    = r_num1[k-1];
                s_num2    = r_num2[k-1];
                n_den[k]  = r_den[k-1];
                n_side[k] = r_side[k-1];
                n_v[k]    = r_v[k-1];
            end
            d  = {1'b0, n_den[k]};
            t1 = {s_rem1, s_num1[NUM_W-1]};
            t2 = {s_rem2, s_num2[NUM_W-1]};
            if (t1 >= d) begin
                n_rem1[k] = DEN_W'(t1 - d);
                n_num1[k] = {s_num1[NUM_W-2:0], 1'b1};
            end else begin
                n_rem1[k] = DEN_W'(t1);
                n_num1[k] = {s_num1[NUM_W-2:0], 1'b0};
            end
            if (t2 >= d) begin
                n_rem2[k] = DEN_W'(t2 - d);
                n_num2[k] = {s_num2[NUM_W-2:0], 1'b1};
            end else begin
                n_rem2[k] = DEN_W'(t2);
                n_num2[k] = {s_num2[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem1 <= n_rem1;
            r_rem2 <= n_rem2;
            r_num1 <= n_num1;
            r_num2 <= n_num2;
            r_den  <= n_den;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo1  = r_num1[NUM_W-1];
    assign o_quo2  = r_num2[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule
`default_nettype wire

// ----- rtl/quadratic_root_solver_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Quadratic root solver.
// Input channel: i_valid / o_ready carry coefficients a, b, c. Output channel:
// o_valid / i_ready carry the root kind and four fixed point values with
// FRAC_BITS fraction bits (two real roots, or real and imaginary parts).
// A transfer happens on a rising edge with valid and ready both high.
// Throughput: one item per cycle while the receiver does not stall.
// ROOT_W = COEF_BITS + FRAC_BITS + 1 (square root, one bit per stage)
// and NUM_W = ROOT_W + 1 (divider, one quotient bit per stage).
// A zero leading coefficient reports its own kind with all values zero.
// Reset (synchronous, active low) empties the pipeline; no item is kept.
// When the receiver stalls, the whole pipeline holds; the input stage still
// takes one transfer if it is empty, then o_ready drops until i_ready returns.
module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COEF_BITS-1:0]  i_coef_quad,
    input  wire logic signed [COEF_BITS-1:0]  i_coef_lin,
    input  wire logic signed [COEF_BITS-1:0]  i_coef_const,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [1:0]                        o_root_kind,
    output logic signed [VAL_W-1:0]           o_root_first,
    output logic signed [VAL_W-1:0]           o_root_second,
    output logic signed [VAL_W-1:0]           o_real_part,
    output logic signed [VAL_W-1:0]           o_imag_part
);

    localparam int CB     = COEF_BITS;
    localparam int PROD_W = 2 * CB;
    localparam int DISC_W = 2 * CB + 3;
    localparam int MAG_W  = 2 * CB + 2;
    localparam int ROOT_W = CB + 1 + FRAC_BITS;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int NUM_W  = ROOT_W + 1;
    localparam int DEN_W  = CB + 1;
    localparam int SIDE_W = 2 + 2 * CB;

    logic adv;
    logic en0;

    logic                     r_v0;
    logic signed [CB-1:0]     r_a0, r_b0, r_c0;
    logic                     r_v1;
    logic signed [CB-1:0]     r_a1, r_b1;
    logic signed [PROD_W-1:0] r_bb, r_ac;
    logic                     r_v2;
    logic signed [CB-1:0]     r_a2, r_b2;
    logic [MAG_W-1:0]         r_mag;
    t_kind                    r_kind2;

    logic signed [DISC_W-1:0] w_disc;
    t_kind                    w_kind2;

    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    logic [SIDE_W-1:0]        sq_side;

    t_kind                    w_kind3;
    logic signed [CB-1:0]     w_a3, w_b3;
    logic signed [NUM_W:0]    w_negb, w_s, w_n1, w_n2;
    logic [CB-1:0]            w_amag;
    t_div_side                w_dside;

    logic                     r_v3;
    logic [NUM_W-1:0]         r_num1, r_num2;
    logic [DEN_W-1:0]         r_den;
    t_div_side                r_dside;

    logic                     dv_valid;
    logic [NUM_W-1:0]         dv_quo1, dv_quo2;
    t_div_side                dv_side;
    logic signed [NUM_W:0]    w_q1, w_q2;
    logic signed [VAL_W-1:0]  w_v1, w_v2;

    logic                     r_ov;
    t_kind                    r_kind;
    logic signed [VAL_W-1:0]  r_first, r_second, r_real, r_imag;

    assign adv     = !r_ov || i_ready;
    assign en0     = adv || !r_v0;
    assign o_ready = en0;

    // discriminant and classification
    always_comb begin
        w_disc = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
        if (r_a1 == '0) begin
            w_kind2 = KIND_NOLEAD;
        end else if (w_disc > 0) begin
            w_kind2 = KIND_TWO;
        end else if (w_disc == 0) begin
            w_kind2 = KIND_DOUBLE;
        end else begin
            w_kind2 = KIND_COMPLEX;
        end
    end

    // numerators and signs for the divider
    always_comb begin
        w_kind3 = t_kind'(sq_side[SIDE_W-1 -: 2]);
        w_a3    = sq_side[2*CB-1:CB];
        w_b3    = sq_side[CB-1:0];
        w_negb  = -((NUM_W+1)'(w_b3) <<< FRAC_BITS);
        w_s     = (NUM_W+1)'({1'b0, sq_root});
        w_amag  = CB'(w_a3[CB-1] ? -w_a3 : w_a3);
        case (w_kind3)
            KIND_TWO: begin
                w_n1 = w_negb + w_s;
                w_n2 = w_negb - w_s;
            end
            KIND_COMPLEX: begin
                w_n1 = w_negb;
                w_n2 = w_s;
            end
            default: begin
                w_n1 = w_negb;
                w_n2 = w_negb;
            end
        endcase
        w_dside.kind = w_kind3;
        w_dside.neg1 = w_n1[NUM_W] ^ w_a3[CB-1];
        w_dside.neg2 = (w_kind3 == KIND_COMPLEX) ? 1'b0 : (w_n2[NUM_W] ^ w_a3[CB-1]);
    end

    // signed quotients for the result selection in the register stage
    always_comb begin
        w_q1 = dv_side.neg1 ? -signed'({1'b0, dv_quo1}) : signed'({1'b0, dv_quo1});
        w_q2 = dv_side.neg2 ? -signed'({1'b0, dv_quo2}) : signed'({1'b0, dv_quo2});
        w_v1 = VAL_W'(w_q1);
        w_v2 = VAL_W'(w_q2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= i_valid;
            end
            if (adv) begin
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_v3 <= sq_valid;
                r_ov <= dv_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_a0 <= i_coef_quad;
            r_b0 <= i_coef_lin;
            r_c0 <= i_coef_const;
        end
        if (adv) begin
            r_a1    <= r_a0;
            r_b1    <= r_b0;
            r_bb    <= r_b0 * r_b0;
            r_ac    <= r_a0 * r_c0;
            r_a2    <= r_a1;
            r_b2    <= r_b1;
            r_kind2 <= w_kind2;
            r_mag   <= MAG_W'(w_disc[DISC_W-1] ? -w_disc : w_disc);
            r_num1  <= NUM_W'(w_n1[NUM_W] ? -w_n1 : w_n1);
            r_num2  <= NUM_W'(w_n2[NUM_W] ? -w_n2 : w_n2);
            r_den   <= {w_amag, 1'b0};
            r_dside <= w_dside;
            r_kind  <= dv_side.kind;
            case (dv_side.kind)
                KIND_TWO: begin
                    r_first  <= w_v1;
                    r_second <= w_v2;
                    r_real   <= '0;
                    r_imag   <= '0;
                end
                KIND_DOUBLE: begin
                    r_first  <= w_v1;
                    r_second <= w_v1;
                    r_real   <= '0;
                    r_imag   <= '0;
                end
                KIND_COMPLEX: begin
                    r_first  <= '0;
                    r_second <= '0;
                    r_real   <= w_v1;
                    r_imag   <= w_v2;
                end
                default: begin
                    r_first  <= '0;
                    r_second <= '0;
                    r_real   <= '0;
                    r_imag   <= '0;
                end
            endcase
        end
    end

    qrs_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v2),
        .i_rad   (RAD_W'(r_mag) << (2 * FRAC_BITS)),
        .i_side  ({r_kind2, r_a2, r_b2}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    qrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v3),
        .i_num1  (r_num1),
        .i_num2  (r_num2),
        .i_den   (r_den),
        .i_side  (r_dside),
        .o_valid (dv_valid),
        .o_quo1  (dv_quo1),
        .o_quo2  (dv_quo2),
        .o_side  (dv_side)
    );

    assign o_valid       = r_ov;
    assign o_root_kind   = r_kind;
    assign o_root_first  = r_first;
    assign o_root_second = r_second;
    assign o_real_part   = r_real;
    assign o_imag_part   = r_imag;

endmodule
`default_nettype wire

// ----- rtl/qrs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker
    import qrs_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     o_valid,
    input  wire logic                     i_ready,
    input  wire logic [1:0]               o_root_kind,
    input  wire logic signed [VAL_W-1:0]  o_root_first,
    input  wire logic signed [VAL_W-1:0]  o_root_second,
    input  wire logic signed [VAL_W-1:0]  o_real_part,
    input  wire logic signed [VAL_W-1:0]  o_imag_part
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_root_kind)
            && $stable(o_root_first) && $stable(o_root_second))
        else $error("output changed during stall");

    a_nolead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == KIND_NOLEAD |-> o_root_first == '0
            && o_root_second == '0 && o_real_part == '0 && o_imag_part == '0)
        else $error("zero leading coefficient with nonzero values");

    a_complex_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == KIND_COMPLEX |-> o_root_first == '0
            && o_root_second == '0 && !o_imag_part[VAL_W-1])
        else $error("complex pair fields wrong");

    a_real_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_kind == KIND_TWO || o_root_kind == KIND_DOUBLE)
            |-> o_real_part == '0 && o_imag_part == '0)
        else $error("real roots with complex parts");

    a_double_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == KIND_DOUBLE |-> o_root_first == o_root_second)
        else $error("double root halves differ");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_root_kind   (o_root_kind),
    .o_root_first  (o_root_first),
    .o_root_second (o_root_second),
    .o_real_part   (o_real_part),
    .o_imag_part   (o_imag_part)
);
`default_nettype wire

// ----- dv/quadratic_root_checker.sv -----
`timescale 1ns / 1ps
module quadratic_root_checker
    import qrs_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      i_in_ready,
    input  wire logic signed [15:0]        i_coef_quad,
    input  wire logic signed [15:0]        i_coef_lin,
    input  wire logic signed [15:0]        i_coef_const,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_ready,
    input  wire logic [1:0]                i_root_kind,
    input  wire logic signed [VAL_W-1:0]   i_root_first,
    input  wire logic signed [VAL_W-1:0]   i_root_second,
    input  wire logic signed [VAL_W-1:0]   i_real_part,
    input  wire logic signed [VAL_W-1:0]   i_imag_part,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        t_kind                   kind;
        logic signed [VAL_W-1:0] r1;
        logic signed [VAL_W-1:0] r2;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } t_roots;

    t_roots root_queue[$];

    function automatic longint isqrt_fixed(longint mag);
        longint rem, root, trial;
        longint pair;
        rem = 0;
        root = 0;
        for (int k = 0; k < 32 + FRAC_BITS_DEF; k++) begin
            pair = (k < 32) ? ((mag >> (62 - 2 * k)) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic t_roots solve_roots(longint a, longint b, longint c);
        t_roots r;
        longint disc, den, negb, s, aden;
        r = '0;
        r.kind = KIND_NOLEAD;
        if (a != 0) begin
            disc = b * b - 4 * a * c;
            den = 2 * a;
            aden = (den < 0) ? -den : den;
            negb = -b * (longint'(1) << FRAC_BITS_DEF);
            if (disc > 0) begin
                s = isqrt_fixed(disc);
                r.r1 = VAL_W'((negb + s) / den);
                r.r2 = VAL_W'((negb - s) / den);
                r.kind = KIND_TWO;
            end else if (disc == 0) begin
                r.r1 = VAL_W'(negb / den);
                r.r2 = r.r1;
                r.kind = KIND_DOUBLE;
            end else begin
                s = isqrt_fixed(-disc);
                r.re = VAL_W'(negb / den);
                r.im = VAL_W'(s / aden);
                r.kind = KIND_COMPLEX;
            end
        end
        return r;
    endfunction

    assign o_pending = root_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_roots exp_r;
        int     errs;
        errs = 0;
        if (i_rst_n && i_valid && i_in_ready)
            root_queue.push_back(solve_roots(i_coef_quad, i_coef_lin, i_coef_const));
        if (i_rst_n && i_out_valid && i_ready) begin
            if (root_queue.size() == 0) begin
                $error("unexpected result transfer");
                errs++;
            end else begin
                exp_r = root_queue.pop_front();
                if (i_root_kind !== exp_r.kind) begin
                    $error("root_kind exp %0d got %0d", exp_r.kind, i_root_kind);
                    errs++;
                end
                if (i_root_first !== exp_r.r1) begin
                    $error("root_first exp %0d got %0d", exp_r.r1, i_root_first);
                    errs++;
                end
                if (i_root_second !== exp_r.r2) begin
                    $error("root_second exp %0d got %0d", exp_r.r2, i_root_second);
                    errs++;
                end
                if (i_real_part !== exp_r.re) begin
                    $error("real_part exp %0d got %0d", exp_r.re, i_real_part);
                    errs++;
                end
                if (i_imag_part !== exp_r.im) begin
                    $error("imag_part exp %0d got %0d", exp_r.im, i_imag_part);
                    errs++;
                end
            end
        end
        if (errs != 0)
            o_fail_count <= o_fail_count + errs;
    end

endmodule

// ----- dv/tb_quadratic_root_solver_unit.sv -----
`timescale 1ns / 1ps
module tb_quadratic_root_solver_unit;
    import qrs_pkg::*;

    localparam int N_RANDOM = 900;
    localparam int N_CALM   = 150;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [15:0]      coef_quad, coef_lin, coef_const;
    logic                    out_valid;
    logic                    out_ready;
    logic [1:0]              root_kind;
    logic signed [VAL_W-1:0] root_first, root_second, real_part, imag_part;
    int                      fail_count;
    int                      pending;
    bit                      calm_out;
    bit                      hold_out;

    quadratic_root_solver_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_coef_quad(coef_quad), .i_coef_lin(coef_lin), .i_coef_const(coef_const),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_root_kind(root_kind), .o_root_first(root_first),
        .o_root_second(root_second), .o_real_part(real_part),
        .o_imag_part(imag_part)
    );

    quadratic_root_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_coef_quad(coef_quad), .i_coef_lin(coef_lin), .i_coef_const(coef_const),
        .i_out_valid(out_valid), .i_ready(out_ready),
        .i_root_kind(root_kind), .i_root_first(root_first),
        .i_root_second(root_second), .i_real_part(real_part),
        .i_imag_part(imag_part),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, a calm stretch, and one long hold-off
    initial begin
        out_ready = 0;
        forever begin
            @(negedge clk);
            if (hold_out)
                out_ready <= 0;
            else if (calm_out)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(99) >= 33);
        end
    end

    initial begin
        hold_out = 0;
        wait (calm_out === 1'b0 && rst_n === 1'b1);
        repeat (400) @(posedge clk);
        hold_out = 1;
        repeat (300) @(posedge clk);
        hold_out = 0;
    end

    task automatic send_coefs(input logic signed [15:0] a, b, c, input bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 33) begin
                in_valid <= 0;
                @(negedge clk);
            end
        end
        in_valid   <= 1;
        coef_quad  <= a;
        coef_lin   <= b;
        coef_const <= c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(16)) - 8);
            3: return 16'(int'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] a, b, k;
        calm_out   = 1;
        rst_n      = 0;
        in_valid   = 0;
        coef_quad  = 0;
        coef_lin   = 0;
        coef_const = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: zero lead, double, two real, complex, extremes
        send_coefs(0, 5, 3, 1);
        send_coefs(0, 0, 0, 1);
        send_coefs(1, -2, 1, 1);
        send_coefs(-3, 12, -12, 1);
        send_coefs(1, 0, -4, 1);
        send_coefs(1, -3, 2, 1);
        send_coefs(1, 0, 1, 1);
        send_coefs(-1, 2, -5, 1);
        send_coefs(3, 1, 7, 1);
        send_coefs(-32768, -32768, -32768, 1);
        send_coefs(-32768, -32768, 32767, 1);
        send_coefs(32767, 32767, 32767, 1);
        send_coefs(32767, -32768, -32768, 1);
        send_coefs(-32768, 0, 32767, 1);
        send_coefs(1, -32768, 0, 1);
        send_coefs(1, 32767, -32768, 1);
        send_coefs(-1, 1, 0, 1);
        send_coefs(7, 0, 0, 1);
        send_coefs(16'sh5555, 16'sh2aaa, 16'shd555, 1);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_CALM)
                calm_out = 0;
            case ($urandom_range(3))
                0: begin // double root: a*(x-k)^2 with small values (zero lead when a is 0)
                    a = 16'(int'($urandom_range(20)) - 10);
                    k = 16'(int'($urandom_range(20)) - 10);
                    send_coefs(a, -2 * a * k, a * k * k, i < N_CALM);
                end
                default: send_coefs(rand_coef(), rand_coef(), rand_coef(), i < N_CALM);
            endcase
        end
        in_valid <= 0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
